// File: rtl/core/utf8v_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 validator package
// Shared types, status codes and the scalar value check for the validator.
// ----------------------------------------------------------------------------
package utf8v_pkg;

  localparam int CP_W = 21;

  // Verdict codes carried on the status field.
  typedef enum logic [1:0] {
    STATUS_CONT   = 2'd0,
    STATUS_ACCEPT = 2'd1,
    STATUS_REJECT = 2'd2
  } status_t;

  localparam logic [7:0] ASCII_MAX   = 8'h7f;
  localparam logic [7:0] LEAD2_LO    = 8'hc2;
  localparam logic [7:0] LEAD2_HI    = 8'hdf;
  localparam logic [7:0] LEAD3_LO    = 8'he0;
  localparam logic [7:0] LEAD3_HI    = 8'hef;
  localparam logic [7:0] LEAD4_LO    = 8'hf0;
  localparam logic [7:0] LEAD4_HI    = 8'hf4;
  localparam logic [7:0] CONT_MASK   = 8'hc0;
  localparam logic [7:0] CONT_TAG    = 8'h80;

  localparam logic [CP_W-1:0] MIN_3BYTE  = 21'h000800;
  localparam logic [CP_W-1:0] MIN_4BYTE  = 21'h010000;
  localparam logic [CP_W-1:0] SURR_LO    = 21'h00d800;
  localparam logic [CP_W-1:0] SURR_HI    = 21'h00dfff;
  localparam logic [CP_W-1:0] CP_MAX     = 21'h10ffff;
  localparam logic [CP_W-1:0] CTRL_LIMIT = 21'h000020;
  localparam logic [CP_W-1:0] LINE_FEED  = 21'h00000a;

  // Decoder state carried from one word to the next.
  typedef struct packed {
    logic [1:0]      bytes_pending;
    logic [1:0]      sequence_length;
    logic [CP_W-1:0] partial_value;
    logic            error_seen;
  } state_t;

  // Result of one word.
  typedef struct packed {
    status_t         status;
    logic            char_complete;
    logic [CP_W-1:0] code_point;
  } result_t;

  // True when a finished sequence yields a legal, allowed scalar value.
  function automatic logic scalar_ok(input logic [CP_W-1:0] cp, input logic [1:0] seq);
    logic ok;
    ok = 1'b1;
    if (seq == 2'd2 && cp < MIN_3BYTE) ok = 1'b0;
    if (seq == 2'd3 && cp < MIN_4BYTE) ok = 1'b0;
    if (cp >= SURR_LO && cp <= SURR_HI) ok = 1'b0;
    if (cp > CP_MAX) ok = 1'b0;
    if (cp < CTRL_LIMIT && cp != LINE_FEED) ok = 1'b0;
    return ok;
  endfunction

endpackage

// File: rtl/core/utf8_strict_validator_core.sv
// ----------------------------------------------------------------------------
// Strict UTF-8 validator core
// Checks a byte string as strict UTF-8 and reports a verdict on every word.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one byte of the string per word, with
//   in_final_byte high on the last byte. Every input word yields exactly
//   one result word on the output channel: the running status (continuing,
//   accepted or rejected), a flag when the byte completed a code point,
//   and the decoded code point in that case (zero otherwise).
//   The result of an accepted word is registered and shows at the output
//   in the cycle after the word is taken. Throughput is one word per cycle
//   while the receiver does not stall, set by the single decode stage
//   between the state registers and the output register.
//   When the receiver stalls, the output register holds its word and the
//   input channel is stalled in the same cycle; a word is taken again as
//   soon as the output word is taken or the output register is empty.
//   Reset clears the decoder state and empties the output register, so the
//   first byte after reset starts a new string. The final byte of each
//   string also clears the decoder state.
// ----------------------------------------------------------------------------
module utf8_strict_validator_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_final_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic                        out_char_complete,
  output logic [utf8v_pkg::CP_W-1:0]  out_code_point
);
  import utf8v_pkg::*;

  state_t  state_r, state_nxt;
  result_t res_r, res_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    in_accept;

  // The output register can take a new word when it is empty or its word
  // leaves in this cycle.
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  utf8v_step u_step (
    .state_i      (state_r),
    .data_byte_i  (in_data_byte),
    .final_byte_i (in_final_byte),
    .state_o      (state_nxt),
    .result_o     (res_nxt)
  );

  always_comb begin
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r & out_stall;
    end
  end

  // Decoder state advances only on an accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        state_r <= state_nxt;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = res_r.status;
  assign out_char_complete = res_r.char_complete;
  assign out_code_point    = res_r.code_point;

  // A final byte always leaves the decoder clean for the next string.
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_final_byte |=> state_r == '0)
    else $error("state not cleared after final byte");

  // An error sticks until the final byte.
  a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !in_final_byte && state_r.error_seen |=> state_r.error_seen)
    else $error("error flag dropped inside a string");

  // After an error no continuation bytes are expected.
  a_error_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.error_seen |-> state_r.bytes_pending == 2'd0)
    else $error("pending count left after error");

  // A completed character is a legal scalar and never carries a rejection.
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.char_complete |->
      res_r.code_point <= CP_MAX && res_r.status != STATUS_REJECT)
    else $error("completed character out of range or rejected");

endmodule

// File: rtl/core/utf8v_step.sv
// ----------------------------------------------------------------------------
// UTF-8 validator step logic
// Combinational decode of one byte against the current decoder state.
// ----------------------------------------------------------------------------
module utf8v_step (
  input  utf8v_pkg::state_t  state_i,
  input  logic [7:0]         data_byte_i,
  input  logic               final_byte_i,
  output utf8v_pkg::state_t  state_o,
  output utf8v_pkg::result_t result_o
);
  import utf8v_pkg::*;

  state_t          st;
  logic            done;
  logic [CP_W-1:0] cp;
  logic [CP_W-1:0] shifted;

  assign shifted = {state_i.partial_value[CP_W-7:0], data_byte_i[5:0]};

  always_comb begin
    st   = state_i;
    done = 1'b0;
    cp   = '0;
    if (!state_i.error_seen) begin
      if (state_i.bytes_pending == 2'd0) begin
        if (data_byte_i <= ASCII_MAX) begin
          if (scalar_ok({13'd0, data_byte_i}, 2'd0)) begin
            done = 1'b1;
            cp   = {13'd0, data_byte_i};
          end else begin
            st.error_seen = 1'b1;
          end
        end else if (data_byte_i >= LEAD2_LO && data_byte_i <= LEAD2_HI) begin
          st.partial_value   = {16'd0, data_byte_i[4:0]};
          st.bytes_pending   = 2'd1;
          st.sequence_length = 2'd1;
        end else if (data_byte_i >= LEAD3_LO && data_byte_i <= LEAD3_HI) begin
          st.partial_value   = {17'd0, data_byte_i[3:0]};
          st.bytes_pending   = 2'd2;
          st.sequence_length = 2'd2;
        end else if (data_byte_i >= LEAD4_LO && data_byte_i <= LEAD4_HI) begin
          st.partial_value   = {18'd0, data_byte_i[2:0]};
          st.bytes_pending   = 2'd3;
          st.sequence_length = 2'd3;
        end else begin
          st.error_seen = 1'b1;
        end
      end else if ((data_byte_i & CONT_MASK) != CONT_TAG) begin
        st.error_seen    = 1'b1;
        st.bytes_pending = 2'd0;
      end else begin
        st.partial_value = shifted;
        st.bytes_pending = state_i.bytes_pending - 2'd1;
        if (state_i.bytes_pending == 2'd1) begin
          if (scalar_ok(shifted, state_i.sequence_length)) begin
            done = 1'b1;
            cp   = shifted;
          end else begin
            st.error_seen = 1'b1;
          end
        end
      end
    end

    result_o.char_complete = done;
    result_o.code_point    = cp;
    if (final_byte_i) begin
      result_o.status = (st.error_seen || st.bytes_pending != 2'd0) ? STATUS_REJECT
                                                                    : STATUS_ACCEPT;
      state_o = '0;
    end else begin
      result_o.status = st.error_seen ? STATUS_REJECT : STATUS_CONT;
      state_o = st;
    end
  end

endmodule

// File: verif/utf8v_check_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 validator verdict scoreboard
// Predicts the verdict word for every byte taken by the validator and checks
// the result words against those predictions in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package utf8v_check_pkg;

  import utf8v_pkg::*;

  class utf8_verdict_board;

    // Decoder state as the block should hold it.
    logic [1:0]      seq_left;
    logic [1:0]      seq_len;
    logic [CP_W-1:0] gathered;
    bit              poisoned;

    result_t         pending_verdicts[$];
    int              mismatches;

    function new();
      clear_string();
      mismatches = 0;
    endfunction

    function void clear_string();
      seq_left = 2'd0;
      seq_len  = 2'd0;
      gathered = '0;
      poisoned = 1'b0;
    endfunction

    // A finished sequence is legal if it is not overlong, not a surrogate,
    // in the Unicode range and not a control other than line feed.
    function bit scalar_legal(logic [CP_W-1:0] v, logic [1:0] len);
      bit overlong;
      overlong = (len == 2'd2 && v < MIN_3BYTE) || (len == 2'd3 && v < MIN_4BYTE);
      return !overlong && !(v >= SURR_LO && v <= SURR_HI) && v <= CP_MAX &&
             (v >= CTRL_LIMIT || v == LINE_FEED);
    endfunction

    function int outstanding();
      return pending_verdicts.size();
    endfunction

    // Called for every byte word the block takes.
    function void note_byte(logic [7:0] b, logic fin);
      result_t want;
      want.char_complete = 1'b0;
      want.code_point    = '0;
      if (!poisoned) begin
        if (seq_left == 2'd0) begin
          if (b <= ASCII_MAX) begin
            if (scalar_legal({13'd0, b}, 2'd0)) begin
              want.char_complete = 1'b1;
              want.code_point    = {13'd0, b};
            end else begin
              poisoned = 1'b1;
            end
          end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            gathered = {16'd0, b[4:0]};
            seq_left = 2'd1;
            seq_len  = 2'd1;
          end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            gathered = {17'd0, b[3:0]};
            seq_left = 2'd2;
            seq_len  = 2'd2;
          end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            gathered = {18'd0, b[2:0]};
            seq_left = 2'd3;
            seq_len  = 2'd3;
          end else begin
            poisoned = 1'b1;
          end
        end else if ((b & CONT_MASK) != CONT_TAG) begin
          poisoned = 1'b1;
          seq_left = 2'd0;
        end else begin
          gathered = {gathered[CP_W-7:0], b[5:0]};
          seq_left = seq_left - 2'd1;
          if (seq_left == 2'd0) begin
            if (scalar_legal(gathered, seq_len)) begin
              want.char_complete = 1'b1;
              want.code_point    = gathered;
            end else begin
              poisoned = 1'b1;
            end
          end
        end
      end
      if (fin) begin
        want.status = (poisoned || seq_left != 2'd0) ? STATUS_REJECT : STATUS_ACCEPT;
        clear_string();
      end else begin
        want.status = poisoned ? STATUS_REJECT : STATUS_CONT;
      end
      pending_verdicts.push_back(want);
    endfunction

    // Called for every result word the testbench takes.
    function void check_verdict(logic [1:0] st, logic cc, logic [CP_W-1:0] cp);
      result_t want;
      if (pending_verdicts.size() == 0) begin
        $error("result word with no verdict expected: status %0d code_point %0h", st, cp);
        mismatches++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (st !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, st);
        mismatches++;
      end
      if (cc !== want.char_complete) begin
        $error("char_complete: expected %0b, actual %0b", want.char_complete, cc);
        mismatches++;
      end
      if (cp !== want.code_point) begin
        $error("code_point: expected %0h, actual %0h", want.code_point, cp);
        mismatches++;
      end
    endfunction

    function void close_out();
      if (pending_verdicts.size() != 0) begin
        $error("%0d expected result words never arrived", pending_verdicts.size());
        mismatches++;
      end
    endfunction

  endclass

endpackage

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// Strict UTF-8 validator testbench
// Feeds byte strings to the validator core under varying sender gaps and
// receiver stalls and checks every result word against a scoreboard that
// predicts the running verdict, the completed flag and the code point.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  import utf8v_pkg::*;
  import utf8v_check_pkg::*;

  // Each result word is registered behind its byte, so a short settle time
  // at the end is plenty. The cycle limit is far above the slowest run.
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int RANDOM_BYTES  = 1850;
  localparam int PHASE_COUNT   = 4;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [7:0]      in_data_byte = 8'h00;
  logic            in_final_byte = 1'b0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [1:0]      out_status;
  logic            out_char_complete;
  logic [CP_W-1:0] out_code_point;

  utf8_verdict_board board;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int              send_gap_pct = 0;
  int              recv_stall_pct = 0;
  int              cycle_count = 0;
  int              bytes_sent = 0;

  // The string being built or sent; the last byte carries the final flag.
  logic [7:0]      str_q[$];

  utf8_strict_validator_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_final_byte     (in_final_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_char_complete (out_char_complete),
    .out_code_point    (out_code_point)
  );

  always #10 clk = ~clk;

  // The receiver stalls at random, at the rate set for the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Both handshakes are sampled at the edge, before any of this edge's
  // updates land. The result check comes first; a byte taken at this edge
  // cannot have its result word taken at the same edge anyway.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        board.check_verdict(out_status, out_char_complete, out_code_point);
      end
      if (in_valid && !in_stall) begin
        board.note_byte(in_data_byte, in_final_byte);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offers one byte word and returns at the edge where it is taken. The
  // task is entered right after a rising edge. Idle cycles before the word
  // drive junk on the payload, which the block must ignore with valid low.
  task automatic send_word(input logic [7:0] b, input logic fin);
    while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid      <= 1'b0;
      in_data_byte  <= 8'($urandom);
      in_final_byte <= 1'($urandom);
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_final_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_string();
    for (int i = 0; i < str_q.size(); i++) begin
      send_word(str_q[i], i == str_q.size() - 1);
    end
    bytes_sent += str_q.size();
  endtask

  // Holds the sender off until every expected result word has been taken.
  // It always waits for an edge, so valid is never lowered and raised in the
  // same step.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.outstanding() != 0);
  endtask

  // Appends the UTF-8 form of a value in the given number of bytes. A
  // longer form than needed gives an overlong sequence; values above the
  // Unicode range give a lead byte or a second byte above the legal range.
  task automatic push_char(input logic [CP_W-1:0] cp, input int n);
    case (n)
      1: begin
        str_q.push_back({1'b0, cp[6:0]});
      end
      2: begin
        str_q.push_back({3'b110, cp[10:6]});
        str_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        str_q.push_back({4'b1110, cp[15:12]});
        str_q.push_back({2'b10, cp[11:6]});
        str_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        str_q.push_back({5'b11110, cp[20:18]});
        str_q.push_back({2'b10, cp[17:12]});
        str_q.push_back({2'b10, cp[11:6]});
        str_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // A legal character of random length and content.
  task automatic push_legal_char();
    logic [CP_W-1:0] cp;
    int              n;
    n = $urandom_range(1, 4);
    case (n)
      1: cp = ($urandom_range(0, 15) == 0) ? LINE_FEED : CP_W'($urandom_range('h20, 'h7f));
      2: cp = CP_W'($urandom_range('h80, 'h7ff));
      3: begin
        cp = CP_W'($urandom_range('h800, 'hffff));
        // Surrogates are shifted down into the legal range below them.
        if (cp >= SURR_LO && cp <= SURR_HI) cp = cp - 21'h800;
      end
      default: cp = CP_W'($urandom_range('h10000, 'h10ffff));
    endcase
    push_char(cp, n);
  endtask

  // A character that must be rejected: overlong, surrogate, beyond the
  // Unicode range, or a control other than line feed.
  task automatic push_illegal_char();
    logic [CP_W-1:0] cp;
    int              n;
    case ($urandom_range(0, 3))
      0: begin
        n  = $urandom_range(2, 4);
        cp = CP_W'($urandom_range(0, (n == 2) ? 'h7f : (n == 3) ? 'h7ff : 'hffff));
      end
      1: begin
        n  = 3;
        cp = CP_W'($urandom_range(SURR_LO, SURR_HI));
      end
      2: begin
        n  = 4;
        cp = CP_W'($urandom_range('h110000, 'h1fffff));
      end
      default: begin
        n  = 1;
        cp = CP_W'($urandom_range(0, 'h1f));
        if (cp == LINE_FEED) cp = '0;
      end
    endcase
    push_char(cp, n);
  endtask

  // Most strings are well formed with random content, so the decoder gets
  // deep into multi-byte sequences. About a quarter carry one fault, and a
  // tenth are plain random bytes.
  task automatic build_string();
    int nchars;
    int pick;
    int bad_at;
    int fault;
    int idx;
    str_q.delete();
    nchars = $urandom_range(1, 10);
    pick   = $urandom_range(0, 99);
    if (pick < 10) begin
      repeat ($urandom_range(1, 8)) str_q.push_back(8'($urandom));
      return;
    end
    fault  = (pick < 35) ? $urandom_range(0, 3) : -1;
    bad_at = $urandom_range(0, nchars - 1);
    for (int c = 0; c < nchars; c++) begin
      if (fault == 0 && c == bad_at) push_illegal_char();
      else push_legal_char();
    end
    idx = $urandom_range(0, str_q.size() - 1);
    case (fault)
      1: str_q[idx] = 8'($urandom);
      2: begin
        // Cutting the tail usually leaves the last sequence unfinished.
        if (str_q.size() > 1) void'(str_q.pop_back());
      end
      3: str_q.insert(idx, {2'b10, 6'($urandom)});
      default: ;
    endcase
  endtask

  initial begin
    board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed strings, no idling. Single printable byte.
    str_q = '{8'h41};
    send_string();
    // Line feed and DEL are both allowed.
    str_q = '{8'h0a, 8'h7f};
    send_string();
    // NUL poisons the string; the following legal byte stays rejected.
    str_q = '{8'h00, 8'h41};
    send_string();
    // Top byte value is never a lead.
    str_q = '{8'hff};
    send_string();
    // Smallest and largest two-byte characters.
    str_q = '{8'hc2, 8'h80, 8'hdf, 8'hbf};
    send_string();
    // Overlong three-byte form, caught on the last continuation.
    str_q = '{8'he0, 8'h9f, 8'hbf};
    send_string();
    // Encoded surrogate.
    str_q = '{8'hed, 8'ha0, 8'h80};
    send_string();
    // One past the top of the Unicode range.
    str_q = '{8'hf4, 8'h90, 8'h80, 8'h80};
    send_string();
    // Sequence cut off by the final byte.
    str_q = '{8'he2, 8'h82};
    send_string();
    // Lead byte followed by a non-continuation byte.
    str_q = '{8'hc3, 8'h41};
    send_string();
    // Largest legal code point.
    str_q = '{8'hf4, 8'h8f, 8'hbf, 8'hbf};
    send_string();
    drain_results();

    // Random strings in phases of sender and receiver idling. The sender
    // waits for every result word between phases.
    bytes_sent = 0;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 82; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 82; end
        default: begin send_gap_pct = 7; recv_stall_pct = 7; end
      endcase
      while (bytes_sent < (ph + 1) * RANDOM_BYTES / PHASE_COUNT) begin
        build_string();
        send_string();
      end
      drain_results();
    end

    recv_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    board.close_out();
    if (board.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
